// ===== hw/rtl/led_bounce_scanner_ir_speed_core_assert.svh =====
// assertion macros shared by the scanner core modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef LED_BOUNCE_SCANNER_IR_SPEED_CORE_ASSERT_SVH
`define LED_BOUNCE_SCANNER_IR_SPEED_CORE_ASSERT_SVH

// same-cycle implication
`define LBS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbs assertion failed");

// next-cycle implication
`define LBS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbs assertion failed");

`endif

// ===== hw/rtl/lbs_pkg.sv =====
// types, constants and helper functions for the led bounce scanner core
// no dependencies; used by every module of the core
package lbs_pkg;

  // matrix geometry
  localparam int unsigned MAT_WIDTH  = 8;
  localparam int unsigned MAT_HEIGHT = 32;

  // infrared command codes
  localparam logic [31:0] CODE_TOGGLE = 32'd16724175;
  localparam logic [31:0] CODE_SLOWER = 32'd16718055;
  localparam logic [31:0] CODE_FASTER = 32'd16743045;
  localparam logic [31:0] CODE_REPEAT = 32'hFFFF_FFFF;

  // limits and reset values
  localparam logic [12:0] RATE_MAX   = 13'd5000;
  localparam logic [12:0] RATE_MIN   = 13'd1;
  localparam logic [12:0] RATE_RESET = 13'd2;
  localparam logic [9:0]  MS_FULL    = 10'd1000;
  localparam logic [7:0]  POS_MIN    = 8'd2;
  localparam logic [7:0]  POS_MAX    = 8'd253;
  localparam logic [7:0]  START_RESET = 8'd193;
  localparam logic [7:0]  END_RESET   = 8'd222;

  // configuration register indexes
  localparam logic [0:0] REG_START_POSITION = 1'b0;
  localparam logic [0:0] REG_END_POSITION   = 1'b1;

  // colour codes
  localparam logic [2:0] COLOR_BLACK = 3'd0;
  localparam logic [2:0] COLOR_BLUE  = 3'd1;
  localparam logic [2:0] COLOR_GREEN = 3'd2;
  localparam logic [2:0] COLOR_RED   = 3'd3;
  localparam logic [2:0] COLOR_WHITE = 3'd4;

  // input item
  typedef struct packed {
    logic        command;
    logic        is_nec;
    logic [31:0] ir_code;
  } lbs_in_t;

  // result item
  typedef struct packed {
    logic [7:0] pixel_address;
    logic [2:0] color;
    logic       last;
  } lbs_out_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic calc;
    logic fire;
    logic load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic due;
    logic last;
  } dp_stat_t;

  // serpentine mapping of a linear index to a matrix address
  function automatic logic [7:0] map_address(logic [7:0] idx);
    logic [31:0] i32;
    logic [31:0] col;
    logic [31:0] row;
    logic [31:0] rev;
    logic [31:0] a;
    i32 = {24'd0, idx};
    col = i32 / MAT_HEIGHT;
    row = i32 % MAT_HEIGHT;
    rev = (MAT_WIDTH - 32'd1 - col) & 32'hFF;
    if (row[0]) begin
      a = row * MAT_WIDTH + rev;
    end else begin
      a = row * MAT_WIDTH + col;
    end
    return a[7:0];
  endfunction

  // colour of write k in the current mode
  function automatic logic [2:0] color_of(logic three, logic [2:0] k);
    logic [2:0] c;
    c = COLOR_BLACK;
    if (three) begin
      case (k)
        3'd1:    c = COLOR_BLUE;
        3'd2:    c = COLOR_GREEN;
        3'd3:    c = COLOR_RED;
        default: c = COLOR_BLACK;
      endcase
    end else begin
      c = (k == 3'd1) ? COLOR_WHITE : COLOR_BLACK;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/led_bounce_scanner_ir_speed_core.sv =====
// tick with no update: input stalled through the calc and test states, then the next item is taken
// tick with update: first pixel write valid after the calc, test and load states, then one write
//   a cycle while out_stall_i is low; next item taken the cycle after the last write
// infrared code: taken with no stall and no writes; the rate check uses one registered multiply
// reset: position 193, moving up, three-colour mode, rate 2, tick count 0
module led_bounce_scanner_ir_speed_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lbs_pkg::lbs_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lbs_pkg::lbs_out_t out_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i
);
  import lbs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing of items and writes
  lbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_tick_i   (!in_i.command),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // scanner state and pixel generation
  lbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_o       (out_o)
  );

endmodule

// ===== hw/rtl/lbs_ctrl.sv =====
// controller state machine of the scanner core
// depends on lbs_pkg and the assertion macro header
`include "led_bounce_scanner_ir_speed_core_assert.svh"

module lbs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_tick_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lbs_pkg::dp_cmd_t cmd_o,
  input  lbs_pkg::dp_stat_t stat_i
);
  import lbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_TEST,
    ST_LOAD,
    ST_SEND
  } state_e;

  state_e state_q;
  logic   in_stall_q;
  logic   out_valid_q;
  logic   take;
  logic   out_take;

  assign take       = in_valid_i && !in_stall_q;
  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

  // datapath commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.take = take;
    unique case (state_q)
      ST_IDLE: cmd_o.take = take;
      ST_CALC: cmd_o.calc = 1'b1;
      ST_TEST: cmd_o.fire = stat_i.due;
      ST_LOAD: cmd_o.load = 1'b1;
      ST_SEND: cmd_o.load = out_take && !stat_i.last;
      default: cmd_o      = '0;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (take && in_tick_i) begin
            in_stall_q <= 1'b1;
            state_q    <= ST_CALC;
          end
        end
        ST_CALC: state_q <= ST_TEST;
        ST_TEST: begin
          if (stat_i.due) begin
            state_q <= ST_LOAD;
          end else begin
            in_stall_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_SEND;
        end
        ST_SEND: begin
          if (out_take && stat_i.last) begin
            out_valid_q <= 1'b0;
            in_stall_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // checks
  `LBS_ASSERT_IMPL(a_idle_no_result, !in_stall_q, !out_valid_q)
  `LBS_ASSERT_NEXT(a_load_shows_result, state_q == ST_LOAD, out_valid_q)
  `LBS_ASSERT_NEXT(a_last_frees_input, out_take && stat_i.last, !in_stall_q && !out_valid_q)

endmodule

// ===== hw/rtl/lbs_datapath.sv =====
// datapath of the scanner core: state registers, rate check and pixel writes
// depends on lbs_pkg and the assertion macro header
`include "led_bounce_scanner_ir_speed_core_assert.svh"

module lbs_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lbs_pkg::lbs_in_t  in_i,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  lbs_pkg::dp_cmd_t  cmd_i,
  output lbs_pkg::dp_stat_t stat_o,
  output lbs_pkg::lbs_out_t out_o
);
  import lbs_pkg::*;

  logic [7:0]  start_q;
  logic [7:0]  end_q;
  logic [7:0]  position_q, position_d;
  logic        moving_up_q;
  logic        three_color_q;
  logic [12:0] rate_q, rate_d;
  logic [9:0]  elapsed_q;
  logic [23:0] product_q;
  logic [2:0]  k_q;
  lbs_out_t    out_q;

  logic [10:0] elapsed_p1;
  logic [12:0] rate_half;
  logic [13:0] rate_dbl;
  logic [2:0]  k_end;
  logic [7:0]  idx;

  // rate update for the speed codes
  always_comb begin
    rate_half = rate_q >> 1;
    rate_dbl  = {rate_q, 1'b0};
    rate_d    = rate_q;
    if (in_i.ir_code == CODE_SLOWER) begin
      rate_d = (rate_half < RATE_MIN) ? RATE_MIN : rate_half;
    end else if (in_i.ir_code == CODE_FASTER) begin
      rate_d = (rate_dbl > {1'b0, RATE_MAX}) ? RATE_MAX : rate_dbl[12:0];
    end
  end

  // position step with saturation
  always_comb begin
    if (moving_up_q) begin
      position_d = (position_q >= POS_MAX) ? POS_MAX : position_q + 8'd1;
    end else begin
      position_d = (position_q <= POS_MIN) ? POS_MIN : position_q - 8'd1;
    end
  end

  // index of the current write
  assign elapsed_p1 = {1'b0, elapsed_q} + 11'd1;
  assign k_end      = three_color_q ? 3'd4 : 3'd2;
  assign idx        = position_q - (three_color_q ? 8'd2 : 8'd1) + {5'd0, k_q};

  assign stat_o.due  = product_q > {14'd0, MS_FULL};
  assign stat_o.last = out_q.last;
  assign out_o       = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RESET;
      end_q   <= END_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_POSITION: start_q <= cfg_data_i;
        REG_END_POSITION:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= START_RESET;
      moving_up_q   <= 1'b1;
      three_color_q <= 1'b1;
      rate_q        <= RATE_RESET;
      elapsed_q     <= '0;
      k_q           <= '0;
    end else begin
      if (cmd_i.take) begin
        if (!in_i.command) begin
          if (elapsed_q < MS_FULL) begin
            elapsed_q <= elapsed_p1[9:0];
          end
        end else if (in_i.is_nec && in_i.ir_code != CODE_REPEAT) begin
          if (in_i.ir_code == CODE_TOGGLE) begin
            three_color_q <= !three_color_q;
          end
          rate_q <= rate_d;
        end
      end
      if (cmd_i.fire) begin
        elapsed_q  <= '0;
        position_q <= position_d;
        k_q        <= '0;
        if (position_d == start_q) begin
          moving_up_q <= 1'b1;
        end else if (position_d == end_q) begin
          moving_up_q <= 1'b0;
        end
      end
      if (cmd_i.load) begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  // interval check product and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      product_q <= 24'(elapsed_p1) * 24'(rate_q);
    end
    if (cmd_i.load) begin
      out_q.pixel_address <= map_address(idx);
      out_q.color         <= color_of(three_color_q, k_q);
      out_q.last          <= (k_q == k_end);
    end
  end

  // checks
  `LBS_ASSERT_IMPL(a_rate_range, 1'b1, rate_q >= RATE_MIN && rate_q <= RATE_MAX)
  `LBS_ASSERT_IMPL(a_elapsed_sat, 1'b1, elapsed_q <= MS_FULL)
  `LBS_ASSERT_NEXT(a_fire_in_range, cmd_i.fire, position_q >= POS_MIN && position_q <= POS_MAX)

endmodule
